FILE: sv/crcc_pkg.sv
// ----------------------------------------------------------------------------
// crcc_pkg
// Shared types and constants of the careful resume window controller.
// ----------------------------------------------------------------------------
`default_nettype none

package crcc_pkg;

    localparam int TIME_BITS   = 48;
    localparam int WORD_BITS   = 32;
    localparam int MINW_BITS   = 21;
    localparam int WIN_BITS    = 24;   // start, first and target windows fit here
    localparam int ADDR_BITS   = 5;
    localparam int SAMPLE_BITS = 16;

    localparam logic [WIN_BITS-1:0]  TARGET_CAP  = 24'd10485760;
    localparam logic [WORD_BITS-1:0] RTT_RISE_US = 32'd10000;
    localparam logic [SAMPLE_BITS-1:0] SAMPLES_TO_VALIDATE = 16'd3;

    // request opcodes
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_ACK     = 3'd1;
    localparam logic [2:0] OP_LOSS    = 3'd2;
    localparam logic [2:0] OP_CHECK   = 3'd3;
    localparam logic [2:0] OP_RETREAT = 3'd4;

    // phases
    localparam logic [2:0] PH_NONE        = 3'd0;
    localparam logic [2:0] PH_RECONNECT   = 3'd1;
    localparam logic [2:0] PH_UNVALIDATED = 3'd2;
    localparam logic [2:0] PH_NORMAL      = 3'd3;
    localparam logic [2:0] PH_RETREAT     = 3'd4;

    // events
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_COMPLETE = 2'd1;
    localparam logic [1:0] EV_RETREAT  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_SAVED_WINDOW   = 3'd0;
    localparam logic [2:0] REG_SAVED_BDP      = 3'd1;
    localparam logic [2:0] REG_SAVED_RTT      = 3'd2;
    localparam logic [2:0] REG_ENTRY_SSTHRESH = 3'd3;
    localparam logic [2:0] REG_MIN_WINDOW     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_JUDGE,
        ST_DIV,
        ST_UPDATE,
        ST_RAMP,
        ST_FINISH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic retreat;
        logic add_ack;
        logic add_loss;
        logic sample;
        logic set_phase;
        logic set_still;
        logic div_init;
        logic div_step;
        logic upd_recon;
        logic ramp_init;
        logic ramp_step;
        logic finish;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       present;
        logic       active;
        logic       rtt_nz;
        logic       path_ok;
        logic       loss_retreat;
        logic       saved_rtt_nz;
        logic       div_last;
        logic       phase_recon;
        logic       rtts_nz;
        logic       ramp_done;
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/crcc_dp.sv
// ----------------------------------------------------------------------------
// crcc_dp
// Datapath: path state, sample checks, elapsed RTT divider, window ramp and
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module crcc_dp #(
    parameter int COUNTER_BITS   = 48,
    parameter int RAMP_MAX_STEPS = 4
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  crcc_pkg::t_cmd                     i_cmd,
    output crcc_pkg::t_stat                    o_stat,
    input  wire  [2:0]                         i_opcode,
    input  wire  [crcc_pkg::TIME_BITS-1:0]     i_now_us,
    input  wire  [crcc_pkg::WORD_BITS-1:0]     i_byte_count,
    input  wire  [crcc_pkg::WORD_BITS-1:0]     i_rtt_sample_us,
    input  wire  [crcc_pkg::WORD_BITS-1:0]     i_saved_window,
    input  wire  [crcc_pkg::WORD_BITS-1:0]     i_saved_bdp,
    input  wire  [crcc_pkg::WORD_BITS-1:0]     i_saved_rtt_us,
    input  wire  [crcc_pkg::WORD_BITS-1:0]     i_entry_ssthresh,
    input  wire  [crcc_pkg::MINW_BITS-1:0]     i_minimum_window,
    output logic                               o_still_resuming,
    output logic                               o_window_write,
    output logic [crcc_pkg::WORD_BITS-1:0]     o_window_value,
    output logic                               o_ssthresh_write,
    output logic [crcc_pkg::WORD_BITS-1:0]     o_ssthresh_value,
    output logic [2:0]                         o_phase_now,
    output logic [1:0]                         o_event_code
);
    import crcc_pkg::*;

    localparam int CB = COUNTER_BITS;
    localparam int RW = WIN_BITS + RAMP_MAX_STEPS;
    localparam int KB = $clog2(RAMP_MAX_STEPS + 1);
    localparam int DB = $clog2(TIME_BITS);

    // latched request
    logic [2:0]           r_op;
    logic [TIME_BITS-1:0] r_now;
    logic [WORD_BITS-1:0] r_bytes;
    logic [WORD_BITS-1:0] r_rtt;

    // path state
    logic                   r_present;
    logic                   r_active;
    logic [2:0]             r_phase;
    logic [WIN_BITS-1:0]    r_target;
    logic [WIN_BITS-1:0]    r_first;
    logic [WIN_BITS-1:0]    r_window;
    logic [CB-1:0]          r_acked;
    logic [CB-1:0]          r_lost;
    logic [WORD_BITS-1:0]   r_rtts;
    logic [TIME_BITS-1:0]   r_stamp;
    logic [WORD_BITS-1:0]   r_rtt_low;
    logic [WORD_BITS-1:0]   r_rtt_high;
    logic [SAMPLE_BITS-1:0] r_samples;
    logic [WORD_BITS-1:0]   r_kept_ssthresh;
    logic                   r_rtt_bad;

    // divider and ramp
    logic [TIME_BITS-1:0] r_div_q;
    logic [WORD_BITS-1:0] r_div_rem;
    logic [DB-1:0]        r_div_cnt;
    logic [RW-1:0]        r_ramp_w;
    logic [KB-1:0]        r_ramp_k;

    // result being built
    logic                 r_res_still;
    logic                 r_res_ww;
    logic [WIN_BITS-1:0]  r_res_wv;
    logic                 r_res_sw;
    logic [WORD_BITS-1:0] r_res_sv;
    logic [2:0]           r_res_phase;
    logic [1:0]           r_res_event;

    // start window and target
    logic [WIN_BITS-1:0]  mw5;
    logic [29:0]          w_quarter;
    logic [WIN_BITS-1:0]  w_capped;
    logic [WIN_BITS-1:0]  w_start;
    logic [WORD_BITS-1:0] t_min;
    logic [WIN_BITS-1:0]  t_start;

    always_comb begin
        mw5       = (WIN_BITS'(i_minimum_window) << 2) + WIN_BITS'(i_minimum_window);
        w_quarter = i_saved_window[WORD_BITS-1:2];
        w_capped  = (w_quarter > 30'(mw5)) ? mw5 : w_quarter[WIN_BITS-1:0];
        w_start   = (w_capped < WIN_BITS'(i_minimum_window)) ?
                    WIN_BITS'(i_minimum_window) : w_capped;
        t_min     = (i_saved_window > i_saved_bdp) ? i_saved_bdp : i_saved_window;
        t_start   = (t_min > WORD_BITS'(TARGET_CAP)) ? TARGET_CAP : t_min[WIN_BITS-1:0];
    end

    // saturating counters
    logic [CB:0]   ack_sum;
    logic [CB:0]   loss_sum;
    logic [CB-1:0] ack_next;
    logic [CB-1:0] loss_next;

    always_comb begin
        ack_sum   = {1'b0, r_acked} + (CB+1)'(r_bytes);
        loss_sum  = {1'b0, r_lost} + (CB+1)'(r_bytes);
        ack_next  = ack_sum[CB] ? '1 : ack_sum[CB-1:0];
        loss_next = loss_sum[CB] ? '1 : loss_sum[CB-1:0];
    end

    // loss share at least six percent: 47*lost >= 3*acked
    logic [CB+5:0] lost47;
    logic [CB+5:0] acked3;
    logic          loss_hi;
    logic [CB:0]   total;

    always_comb begin
        lost47  = ((CB+6)'(r_lost) << 5) + ((CB+6)'(r_lost) << 4) - (CB+6)'(r_lost);
        acked3  = ((CB+6)'(r_acked) << 1) + (CB+6)'(r_acked);
        loss_hi = (lost47 >= acked3);
        total   = {1'b0, r_acked} + {1'b0, r_lost};
    end

    // sample verdict
    logic rtt_bad_n;
    always_comb begin
        rtt_bad_n = ({1'b0, r_rtt} > {i_saved_rtt_us, 1'b0}) &&
                    ((r_rtt - i_saved_rtt_us) > RTT_RISE_US);
    end

    // divider step
    logic [TIME_BITS-1:0] elapsed;
    logic [WORD_BITS:0]   rem2;
    logic                 q_bit;
    logic [WORD_BITS:0]   rem_diff;
    logic [TIME_BITS-1:0] q_next;
    logic [WORD_BITS-1:0] n32;

    always_comb begin
        elapsed  = (r_now >= r_stamp) ? (r_now - r_stamp) : '0;
        rem2     = {r_div_rem, r_div_q[TIME_BITS-1]};
        q_bit    = (rem2 >= {1'b0, i_saved_rtt_us});
        rem_diff = q_bit ? (rem2 - {1'b0, i_saved_rtt_us}) : rem2;
        q_next   = {r_div_q[TIME_BITS-2:0], q_bit};
        n32      = (|q_next[TIME_BITS-1:WORD_BITS]) ? '1 : q_next[WORD_BITS-1:0];
    end

    // ramp and end of resume
    logic [WIN_BITS-1:0] w_final;
    logic                resume_done;

    always_comb begin
        if (r_rtts != '0) begin
            w_final = (r_ramp_w > RW'(r_target)) ? r_target : r_ramp_w[WIN_BITS-1:0];
        end else begin
            w_final = r_window;
        end
        resume_done = (w_final >= r_target) ||
                      (r_acked >= CB'({r_target, 1'b0})) ||
                      (r_rtts >= WORD_BITS'(RAMP_MAX_STEPS));
    end

    always_comb begin
        o_stat.op           = r_op;
        o_stat.present      = r_present;
        o_stat.active       = r_active;
        o_stat.rtt_nz       = (r_rtt != '0);
        o_stat.path_ok      = !r_rtt_bad && !((r_acked != '0) && loss_hi);
        o_stat.loss_retreat = (total > (CB+1)'(r_first)) && loss_hi;
        o_stat.saved_rtt_nz = (i_saved_rtt_us != '0);
        o_stat.div_last     = (r_div_cnt == DB'(TIME_BITS - 1));
        o_stat.phase_recon  = (r_phase == PH_RECONNECT);
        o_stat.rtts_nz      = (r_rtts != '0);
        o_stat.ramp_done    = (WORD_BITS'(r_ramp_k) >= r_rtts) ||
                              (r_ramp_k == KB'(RAMP_MAX_STEPS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present       <= 1'b0;
            r_active        <= 1'b0;
            r_phase         <= PH_NONE;
            r_target        <= '0;
            r_first         <= '0;
            r_window        <= '0;
            r_acked         <= '0;
            r_lost          <= '0;
            r_rtts          <= '0;
            r_stamp         <= '0;
            r_rtt_low       <= '1;
            r_rtt_high      <= '0;
            r_samples       <= '0;
            r_kept_ssthresh <= '0;
            r_rtt_bad       <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rtt_bad <= 1'b0;
            end
            if (i_cmd.start || i_cmd.retreat) begin
                r_present       <= i_cmd.start;
                r_active        <= i_cmd.start;
                r_phase         <= i_cmd.start ? PH_RECONNECT : PH_NONE;
                r_target        <= i_cmd.start ? t_start : '0;
                r_first         <= i_cmd.start ? w_start : '0;
                r_window        <= i_cmd.start ? w_start : '0;
                r_acked         <= '0;
                r_lost          <= '0;
                r_rtts          <= '0;
                r_stamp         <= i_cmd.start ? r_now : '0;
                r_rtt_low       <= '1;
                r_rtt_high      <= '0;
                r_samples       <= '0;
                r_kept_ssthresh <= i_cmd.start ? i_entry_ssthresh : '0;
            end
            if (i_cmd.add_ack) begin
                r_acked <= ack_next;
            end
            if (i_cmd.add_loss) begin
                r_lost <= loss_next;
            end
            if (i_cmd.sample) begin
                if (r_samples != '1) begin
                    r_samples <= r_samples + 1'b1;
                end
                if (r_rtt < r_rtt_low) begin
                    r_rtt_low <= r_rtt;
                end
                if (r_rtt > r_rtt_high) begin
                    r_rtt_high <= r_rtt;
                end
                r_rtt_bad <= rtt_bad_n;
            end
            if (i_cmd.div_step && o_stat.div_last && (n32 > r_rtts)) begin
                r_rtts <= n32;
            end
            if (i_cmd.upd_recon && (r_samples >= SAMPLES_TO_VALIDATE)) begin
                r_phase <= PH_UNVALIDATED;
            end
            if (i_cmd.finish) begin
                if (r_rtts != '0) begin
                    r_window <= w_final;
                end
                if (resume_done) begin
                    r_phase  <= PH_NORMAL;
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_opcode;
            r_now       <= i_now_us;
            r_bytes     <= i_byte_count;
            r_rtt       <= i_rtt_sample_us;
            r_res_still <= 1'b0;
            r_res_ww    <= 1'b0;
            r_res_wv    <= '0;
            r_res_sw    <= 1'b0;
            r_res_sv    <= '0;
            r_res_phase <= PH_NONE;
            r_res_event <= EV_NONE;
        end
        if (i_cmd.start) begin
            r_res_ww    <= 1'b1;
            r_res_wv    <= w_start;
            r_res_phase <= PH_RECONNECT;
        end
        if (i_cmd.retreat) begin
            r_res_still <= 1'b0;
            r_res_ww    <= 1'b1;
            r_res_wv    <= WIN_BITS'(i_minimum_window);
            r_res_sw    <= 1'b1;
            r_res_sv    <= r_kept_ssthresh;
            r_res_phase <= PH_RETREAT;
            r_res_event <= EV_RETREAT;
        end
        if (i_cmd.set_phase) begin
            r_res_phase <= r_phase;
        end
        if (i_cmd.set_still) begin
            r_res_still <= o_stat.path_ok;
        end
        if (i_cmd.upd_recon) begin
            r_res_still <= 1'b1;
            r_res_phase <= (r_samples >= SAMPLES_TO_VALIDATE) ? PH_UNVALIDATED : r_phase;
        end
        if (i_cmd.div_init) begin
            r_div_q   <= elapsed;
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_q   <= q_next;
            r_div_rem <= rem_diff[WORD_BITS-1:0];
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.ramp_init) begin
            r_ramp_w <= RW'(r_first);
            r_ramp_k <= '0;
        end
        if (i_cmd.ramp_step) begin
            r_ramp_w <= r_ramp_w + (r_ramp_w >> 1);
            r_ramp_k <= r_ramp_k + 1'b1;
        end
        if (i_cmd.finish) begin
            if (r_rtts != '0) begin
                r_res_ww <= 1'b1;
                r_res_wv <= w_final;
            end
            if (resume_done) begin
                r_res_still <= 1'b0;
                r_res_phase <= PH_NORMAL;
                r_res_event <= EV_COMPLETE;
            end else begin
                r_res_still <= 1'b1;
                r_res_phase <= r_phase;
            end
        end
        if (i_cmd.emit) begin
            o_still_resuming <= r_res_still;
            o_window_write   <= r_res_ww;
            o_window_value   <= WORD_BITS'(r_res_wv);
            o_ssthresh_write <= r_res_sw;
            o_ssthresh_value <= r_res_sv;
            o_phase_now      <= r_res_phase;
            o_event_code     <= r_res_event;
        end
    end

endmodule

`default_nettype wire

FILE: sv/crcc_ctrl.sv
// ----------------------------------------------------------------------------
// crcc_ctrl
// Sequencer: steps one request through the datapath and owns the result
// handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module crcc_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  crcc_pkg::t_stat  i_stat,
    output crcc_pkg::t_cmd   o_cmd
);
    import crcc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_stat.op == OP_START) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_EMIT;
                end else if (i_stat.op == OP_RETREAT) begin
                    o_cmd.retreat = i_stat.present;
                    n_state       = ST_EMIT;
                end else begin
                    o_cmd.set_phase = 1'b1;
                    if (!i_stat.present || !i_stat.active || i_stat.op > OP_RETREAT) begin
                        n_state = ST_EMIT;
                    end else begin
                        o_cmd.sample   = (i_stat.op == OP_CHECK) ||
                                         ((i_stat.op == OP_ACK) && i_stat.rtt_nz);
                        o_cmd.add_ack  = (i_stat.op == OP_ACK);
                        o_cmd.add_loss = (i_stat.op == OP_LOSS);
                        n_state        = ST_JUDGE;
                    end
                end
            end
            ST_JUDGE: begin
                unique case (i_stat.op)
                    OP_CHECK: begin
                        o_cmd.set_still = 1'b1;
                        n_state         = ST_EMIT;
                    end
                    OP_LOSS: begin
                        o_cmd.retreat = i_stat.loss_retreat;
                        n_state       = ST_EMIT;
                    end
                    OP_ACK: begin
                        if (i_stat.rtt_nz && !i_stat.path_ok) begin
                            o_cmd.retreat = 1'b1;
                            n_state       = ST_EMIT;
                        end else if (i_stat.saved_rtt_nz) begin
                            o_cmd.div_init = 1'b1;
                            n_state        = ST_DIV;
                        end else begin
                            n_state = ST_UPDATE;
                        end
                    end
                    default: begin
                        n_state = ST_EMIT;
                    end
                endcase
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (i_stat.phase_recon) begin
                    o_cmd.upd_recon = 1'b1;
                    n_state         = ST_EMIT;
                end else if (i_stat.rtts_nz) begin
                    o_cmd.ramp_init = 1'b1;
                    n_state         = ST_RAMP;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_RAMP: begin
                if (i_stat.ramp_done) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.ramp_step = 1'b1;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: sv/careful_resume_cwnd_controller_core.sv
// ----------------------------------------------------------------------------
// careful_resume_cwnd_controller_core
// Careful resume congestion window controller for one path.
// ----------------------------------------------------------------------------
// One request in, one result out. Start, retreat, unknown opcodes and requests
// on an idle path go from dispatch straight to the result; check and loss pass
// through the judge first. An ack can also run the bit-serial divider that
// turns elapsed time into saved RTTs (48 steps) and the ramp, one 3/2 step
// per cycle. A new request is taken once the previous one has moved into the
// output register, while that result still waits for its sink.
`default_nettype none

module careful_resume_cwnd_controller_core #(
    parameter int RAMP_MAX_STEPS = 4,
    parameter int COUNTER_BITS   = 48
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire  [111:0] i_s_axis_tdata,   // now_us[47:0], byte_count, rtt_sample_us
    input  wire  [2:0]   i_s_axis_tuser,   // opcode
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // still_resuming, window_write, window_value[31:0], ssthresh_write,
    // ssthresh_value[31:0], phase_now[2:0], event_code[1:0]
    output logic [71:0]  o_m_axis_tdata,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [crcc_pkg::ADDR_BITS-1:0] paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import crcc_pkg::*;

    logic [WORD_BITS-1:0] r_saved_window;
    logic [WORD_BITS-1:0] r_saved_bdp;
    logic [WORD_BITS-1:0] r_base_rtt;
    logic [WORD_BITS-1:0] r_entry_ssthresh;
    logic [MINW_BITS-1:0] r_min_window;
    logic [2:0]           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saved_window   <= '0;
            r_saved_bdp      <= '0;
            r_base_rtt       <= '0;
            r_entry_ssthresh <= '0;
            r_min_window     <= 21'd2400;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_SAVED_WINDOW:   r_saved_window   <= pwdata;
                REG_SAVED_BDP:      r_saved_bdp      <= pwdata;
                REG_SAVED_RTT:      r_base_rtt       <= pwdata;
                REG_ENTRY_SSTHRESH: r_entry_ssthresh <= pwdata;
                REG_MIN_WINDOW:     r_min_window     <= pwdata[MINW_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SAVED_WINDOW:   prdata = r_saved_window;
            REG_SAVED_BDP:      prdata = r_saved_bdp;
            REG_SAVED_RTT:      prdata = r_base_rtt;
            REG_ENTRY_SSTHRESH: prdata = r_entry_ssthresh;
            REG_MIN_WINDOW:     prdata = 32'(r_min_window);
            default:            prdata = '0;
        endcase
    end

    t_cmd  cmd;
    t_stat stat;

    crcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    crcc_dp #(
        .COUNTER_BITS   (COUNTER_BITS),
        .RAMP_MAX_STEPS (RAMP_MAX_STEPS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_opcode         (i_s_axis_tuser),
        .i_now_us         (i_s_axis_tdata[47:0]),
        .i_byte_count     (i_s_axis_tdata[79:48]),
        .i_rtt_sample_us  (i_s_axis_tdata[111:80]),
        .i_saved_window   (r_saved_window),
        .i_saved_bdp      (r_saved_bdp),
        .i_saved_rtt_us   (r_base_rtt),
        .i_entry_ssthresh (r_entry_ssthresh),
        .i_minimum_window (r_min_window),
        .o_still_resuming (o_m_axis_tdata[0]),
        .o_window_write   (o_m_axis_tdata[1]),
        .o_window_value   (o_m_axis_tdata[33:2]),
        .o_ssthresh_write (o_m_axis_tdata[34]),
        .o_ssthresh_value (o_m_axis_tdata[66:35]),
        .o_phase_now      (o_m_axis_tdata[69:67]),
        .o_event_code     (o_m_axis_tdata[71:70])
    );

endmodule

`default_nettype wire

FILE: sv/crcc_checker.sv
// ----------------------------------------------------------------------------
// crcc_checker
// Port-level checks of the careful resume window controller.
// ----------------------------------------------------------------------------
`default_nettype none

module crcc_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_m_axis_tvalid,
    input wire         i_m_axis_tready,
    input wire [71:0]  o_m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // retreat drops window, restores ssthresh, reports retreat phase
    a_retreat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[71:70] == 2'd2) |->
        o_m_axis_tdata[1] && o_m_axis_tdata[34] && (o_m_axis_tdata[69:67] == 3'd4)
        && !o_m_axis_tdata[0])
        else $error("retreat result inconsistent");

    // completion lands in normal phase and ends resume
    a_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[71:70] == 2'd1) |->
        (o_m_axis_tdata[69:67] == 3'd3) && !o_m_axis_tdata[0] && !o_m_axis_tdata[34])
        else $error("completion result inconsistent");

    // no write, no value
    a_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[1] |->
        (o_m_axis_tdata[33:2] == 32'd0) && (o_m_axis_tdata[71:70] != 2'd2))
        else $error("window value without write");

endmodule

bind careful_resume_cwnd_controller_core crcc_checker u_crcc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
